@@ hw/rtl/esc_throttle_and_current_limit_unit_macros.svh @@
// assertion macros for the throttle and current limit unit
`ifndef ESC_THROTTLE_AND_CURRENT_LIMIT_UNIT_MACROS_SVH
`define ESC_THROTTLE_AND_CURRENT_LIMIT_UNIT_MACROS_SVH

// same-cycle implication
`define ETCL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ETCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/esc_tcl_pkg.sv @@
package esc_tcl_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PWM        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PPM        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_LIMIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIDTH   = 3'd5;

    localparam logic [7:0] RST_MAX_PWM    = 8'd255;
    localparam logic [7:0] RST_MIN_PWM    = 8'd5;
    localparam logic [7:0] RST_MIN_PPM    = 8'd10;
    localparam logic [9:0] RST_FAST_LIMIT = 10'd200;
    localparam logic [7:0] RST_AVG_LIMIT  = 8'd120;

    localparam logic [9:0] PPM_INVALID_ABOVE = 10'd300;
    localparam logic [9:0] PPM_FULL          = 10'd200;
    localparam logic [7:0] PPM_TOP           = 8'd190;
    localparam logic [7:0] SIO_FULL          = 8'd200;

    localparam int QUO_W     = 16;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic       i2c_valid;
        logic [7:0] i2c_value;
        logic       sio_valid;
        logic [7:0] sio_value;
        logic       ppm_valid;
        logic [9:0] ppm_value;
        logic [9:0] motor_current;
        logic       average_tick;
    } t_in_beat;

    typedef struct packed {
        logic [8:0] duty_wide;
        logic [7:0] duty_narrow;
        logic [7:0] setpoint;
        logic [7:0] duty_ceiling;
        logic [7:0] average_current;
        logic       overcurrent;
        logic       warning_led;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

endpackage

@@ hw/rtl/esc_throttle_and_current_limit_unit.sv @@
// channel | direction | handshake                  | beat
// in      | input     | i_in_valid / o_in_ready    | esc_tcl_pkg::t_in_beat
// out     | output    | o_out_valid / i_out_ready  | esc_tcl_pkg::t_out_beat
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one beat at a time: a serial setpoint, or a pulse-width setpoint above the minimum, runs through
// prep, 8x8 multiply, 16 restoring divide steps and finish; the result and a free input both
// follow finish; bus, decay and other direct setpoints skip the multiply and divider, prep to finish
// i_rst_n is synchronous active low; state, config and limiter registers return to their reset values
// a new input beat is taken while a result still waits; finish holds if out is stalled
// cfg writes are always ready

`include "esc_throttle_and_current_limit_unit_macros.svh"

module esc_throttle_and_current_limit_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  esc_tcl_pkg::t_in_beat                 i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output esc_tcl_pkg::t_out_beat                o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [esc_tcl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [esc_tcl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    esc_tcl_pkg::t_state    r_state, n_state;
    esc_tcl_pkg::t_in_beat  r_in, n_in;
    esc_tcl_pkg::t_out_beat r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic [7:0] r_max_pwm, n_max_pwm;
    logic [7:0] r_min_pwm, n_min_pwm;
    logic [7:0] r_min_ppm, n_min_ppm;
    logic [9:0] r_fast_lim, n_fast_lim;
    logic [7:0] r_avg_lim, n_avg_lim;
    logic       r_dbl, n_dbl;

    logic [7:0] r_held, n_held;
    logic [9:0] r_avg, n_avg;
    logic [7:0] r_ceil, n_ceil;
    logic       r_red, n_red;

    logic [7:0]                    r_mul_a, n_mul_a;
    logic [7:0]                    r_mul_b, n_mul_b;
    logic [7:0]                    r_div_d, n_div_d;
    logic [esc_tcl_pkg::QUO_W-1:0] r_quo, n_quo;
    logic [7:0]                    r_rem, n_rem;
    logic [esc_tcl_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_neg, n_neg;
    logic [7:0]                    r_base, n_base;
    logic                          r_direct, n_direct;
    logic [7:0]                    r_sp_raw, n_sp_raw;

    logic                          in_fire;
    logic                          fin_go;
    logic [9:0]                    ppm_a;
    logic [7:0]                    ppm_c;
    logic [8:0]                    trial;
    logic                          trial_ge;
    logic [8:0]                    trial_diff;
    logic [16:0]                   val;
    logic [7:0]                    sp;
    logic [7:0]                    duty;
    logic                          over;
    logic                          clip;
    logic                          avg_hot;

    assign o_in_ready  = (r_state == esc_tcl_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_fire     = i_in_valid && o_in_ready;
    assign fin_go      = (r_state == esc_tcl_pkg::S_FIN) && (!r_out_valid || i_out_ready);

    // pulse width conditioning
    assign ppm_a = (r_in.ppm_value > esc_tcl_pkg::PPM_INVALID_ABOVE) ? 10'd0 : r_in.ppm_value;
    assign ppm_c = (ppm_a > esc_tcl_pkg::PPM_FULL) ? esc_tcl_pkg::PPM_FULL[7:0] : ppm_a[7:0];

    // restoring divide step
    assign trial      = {r_rem, r_quo[esc_tcl_pkg::QUO_W-1]};
    assign trial_ge   = (trial >= {1'b0, r_div_d});
    assign trial_diff = trial - {1'b0, r_div_d};

    // finish datapath
    always_comb begin
        if (r_direct) begin
            val = {9'd0, r_sp_raw};
        end else if (r_neg) begin
            val = (r_quo > {8'd0, r_base}) ? 17'd0 : 17'({8'd0, r_base} - r_quo);
        end else begin
            val = 17'(r_base) + 17'(r_quo);
        end
    end

    assign sp   = (val > 17'(r_max_pwm)) ? r_max_pwm : val[7:0];
    assign clip = (sp > r_ceil);
    assign duty = clip ? r_ceil : sp;
    assign over = (r_in.motor_current > r_fast_lim);

    always_comb begin
        n_avg = r_avg;
        if (r_in.average_tick) begin
            if (r_avg < r_in.motor_current) begin
                n_avg = r_avg + 10'd1;
            end else if (r_avg > r_in.motor_current) begin
                n_avg = r_avg - 10'd1;
            end
        end
    end

    assign avg_hot = r_in.average_tick && (n_avg > {2'd0, r_avg_lim});

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_max_pwm   = r_max_pwm;
        n_min_pwm   = r_min_pwm;
        n_min_ppm   = r_min_ppm;
        n_fast_lim  = r_fast_lim;
        n_avg_lim   = r_avg_lim;
        n_dbl       = r_dbl;
        n_held      = r_held;
        n_ceil      = r_ceil;
        n_red       = r_red;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_div_d     = r_div_d;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_base      = r_base;
        n_direct    = r_direct;
        n_sp_raw    = r_sp_raw;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                esc_tcl_pkg::REG_MAX_PWM:      n_max_pwm  = i_cfg_data[7:0];
                esc_tcl_pkg::REG_MIN_PWM:      n_min_pwm  = i_cfg_data[7:0];
                esc_tcl_pkg::REG_MIN_PPM:      n_min_ppm  = i_cfg_data[7:0];
                esc_tcl_pkg::REG_FAST_LIMIT:   n_fast_lim = i_cfg_data[9:0];
                esc_tcl_pkg::REG_AVG_LIMIT:    n_avg_lim  = i_cfg_data[7:0];
                esc_tcl_pkg::REG_DOUBLE_WIDTH: n_dbl      = i_cfg_data[0];
                default: ;
            endcase
        end

        case (r_state)
            esc_tcl_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_in    = i_in_data;
                    n_state = esc_tcl_pkg::S_PREP;
                end
            end
            esc_tcl_pkg::S_PREP: begin
                n_direct = 1'b1;
                n_neg    = 1'b0;
                n_base   = 8'd0;
                n_sp_raw = 8'd0;
                n_mul_a  = r_max_pwm;
                n_mul_b  = r_in.sio_value;
                n_div_d  = esc_tcl_pkg::SIO_FULL;
                if (r_in.i2c_valid) begin
                    n_sp_raw = r_in.i2c_value;
                    n_red    = 1'b0;
                end else if (r_in.sio_valid) begin
                    n_direct = 1'b0;
                end else if (r_in.ppm_valid) begin
                    n_red = 1'b0;
                    if (ppm_c <= r_min_ppm) begin
                        n_sp_raw = 8'd0;
                    end else if (r_min_ppm >= esc_tcl_pkg::PPM_TOP) begin
                        n_sp_raw = r_max_pwm;
                    end else begin
                        n_direct = 1'b0;
                        n_neg    = (r_min_pwm > r_max_pwm);
                        n_mul_a  = (r_min_pwm > r_max_pwm) ? (r_min_pwm - r_max_pwm)
                                                           : (r_max_pwm - r_min_pwm);
                        n_mul_b  = ppm_c - r_min_ppm;
                        n_div_d  = esc_tcl_pkg::PPM_TOP - r_min_ppm;
                        n_base   = r_min_pwm;
                    end
                end else begin
                    n_sp_raw = (r_held != 8'd0) ? (r_held - 8'd1) : 8'd0;
                    n_red    = 1'b1;
                end
                n_state = n_direct ? esc_tcl_pkg::S_FIN : esc_tcl_pkg::S_MUL;
            end
            esc_tcl_pkg::S_MUL: begin
                n_quo   = 16'(r_mul_a) * 16'(r_mul_b);
                n_rem   = 8'd0;
                n_cnt   = '0;
                n_state = esc_tcl_pkg::S_DIV;
            end
            esc_tcl_pkg::S_DIV: begin
                n_rem = trial_ge ? trial_diff[7:0] : trial[7:0];
                n_quo = {r_quo[esc_tcl_pkg::QUO_W-2:0], trial_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == esc_tcl_pkg::CNT_W'(esc_tcl_pkg::DIV_STEPS - 1)) begin
                    n_state = esc_tcl_pkg::S_FIN;
                end
            end
            esc_tcl_pkg::S_FIN: begin
                if (fin_go) begin
                    n_held = sp;
                    n_ceil = r_ceil;
                    if (r_in.average_tick) begin
                        if (avg_hot) begin
                            n_ceil = (r_ceil != 8'd0) ? (r_ceil - 8'd1) : 8'd0;
                        end else if (r_ceil < r_max_pwm) begin
                            n_ceil = r_ceil + 8'd1;
                        end
                    end
                    n_red = r_red | clip | over | avg_hot;
                    n_out.duty_wide       = over ? 9'd0 : (r_dbl ? {duty, 1'b0} : {1'b0, duty});
                    n_out.duty_narrow     = over ? 8'd0 : duty;
                    n_out.setpoint        = sp;
                    n_out.duty_ceiling    = n_ceil;
                    n_out.average_current = n_avg[7:0];
                    n_out.overcurrent     = over;
                    n_out.warning_led     = n_red;
                    n_out_valid           = 1'b1;
                    n_state               = esc_tcl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = esc_tcl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esc_tcl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_max_pwm   <= esc_tcl_pkg::RST_MAX_PWM;
            r_min_pwm   <= esc_tcl_pkg::RST_MIN_PWM;
            r_min_ppm   <= esc_tcl_pkg::RST_MIN_PPM;
            r_fast_lim  <= esc_tcl_pkg::RST_FAST_LIMIT;
            r_avg_lim   <= esc_tcl_pkg::RST_AVG_LIMIT;
            r_dbl       <= 1'b0;
            r_held      <= 8'd0;
            r_avg       <= 10'd0;
            r_ceil      <= esc_tcl_pkg::RST_MAX_PWM;
            r_red       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_max_pwm   <= n_max_pwm;
            r_min_pwm   <= n_min_pwm;
            r_min_ppm   <= n_min_ppm;
            r_fast_lim  <= n_fast_lim;
            r_avg_lim   <= n_avg_lim;
            r_dbl       <= n_dbl;
            r_held      <= n_held;
            // average level only moves on a finished pass
            if (fin_go) begin
                r_avg <= n_avg;
            end
            r_ceil      <= n_ceil;
            r_red       <= n_red;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_out    <= n_out;
        r_mul_a  <= n_mul_a;
        r_mul_b  <= n_mul_b;
        r_div_d  <= n_div_d;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_base   <= n_base;
        r_direct <= n_direct;
        r_sp_raw <= n_sp_raw;
    end

    `ETCL_ASSERT_NOW(a_ovc_zero, i_clk, i_rst_n, o_out_valid && o_out_data.overcurrent, o_out_data.duty_wide == 9'd0 && o_out_data.duty_narrow == 8'd0, "overcurrent result with nonzero duty")
    `ETCL_ASSERT_NOW(a_sp_bound, i_clk, i_rst_n, o_out_valid, o_out_data.duty_narrow <= o_out_data.setpoint && o_out_data.setpoint <= r_max_pwm, "duty or setpoint above its bound")
    `ETCL_ASSERT_NEXT(a_one_beat, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second beat taken while busy")
    `ETCL_ASSERT_NEXT(a_div_end, i_clk, i_rst_n, r_state == esc_tcl_pkg::S_DIV && r_cnt == esc_tcl_pkg::CNT_W'(esc_tcl_pkg::DIV_STEPS - 1), r_state == esc_tcl_pkg::S_FIN, "divider did not hand over to finish")

endmodule
